// File: hw/rtl/aacsd_pkg.sv
// shared types, constants and helpers of the aac section data parser
package aacsd_pkg;

  localparam logic [2:0] CODEBOOK_BITS     = 3'd4;
  localparam logic [2:0] LONG_LENGTH_BITS  = 3'd5;
  localparam logic [2:0] SHORT_LENGTH_BITS = 3'd3;
  localparam logic [4:0] LONG_ESC          = 5'd31;
  localparam logic [4:0] SHORT_ESC         = 5'd7;

  localparam logic [1:0] REG_IS_LONG          = 2'd0;
  localparam logic [1:0] REG_BANDS_PER_WINDOW = 2'd1;
  localparam logic [1:0] REG_MAX_BAND         = 2'd2;
  localparam logic [1:0] REG_TOTAL_BANDS      = 2'd3;

  typedef struct packed {
    logic       is_long;
    logic [5:0] bands_per_window;
    logic [5:0] max_band;
    logic [6:0] total_bands;
  } cfg_t;

  typedef struct packed {
    logic [3:0] codebook;
    logic [7:0] section_end;
    logic       is_filler;
    logic       last;
    logic       error;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic [4:0] shift;
    logic [2:0] taken;
    logic       reading;
    logic [3:0] cb;
    logic [7:0] bp;
    logic [7:0] sc;
    logic [7:0] used_edge;
    logic       finished;
  } parse_st_t;

  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

// File: hw/rtl/aacsd_core.sv
// bit-serial section data parse: field shifter, band counters, result forming
module aacsd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             stream_bit,
  input  logic             start_req,
  input  aacsd_pkg::cfg_t  cfg,
  output aacsd_pkg::push_t push
);

  aacsd_pkg::parse_st_t st, st_next;

  logic [4:0]       shift_v;
  logic [2:0]       taken_v;
  logic [2:0]       len_bits;
  logic [4:0]       len_val;
  logic [4:0]       esc;
  logic [7:0]       total8;
  logic [7:0]       bp1;
  logic [7:0]       bp2;
  logic signed [9:0] nb;
  logic             done;
  logic             err;

  always_comb begin
    st_next  = st;
    push     = '0;
    shift_v  = '0;
    taken_v  = '0;
    bp1      = '0;
    bp2      = '0;
    nb       = '0;
    done     = 1'b0;
    err      = 1'b0;
    total8   = {1'b0, cfg.total_bands};
    len_bits = cfg.is_long ? aacsd_pkg::LONG_LENGTH_BITS : aacsd_pkg::SHORT_LENGTH_BITS;
    esc      = cfg.is_long ? aacsd_pkg::LONG_ESC : aacsd_pkg::SHORT_ESC;
    len_val  = '0;
    if (step) begin
      if (start_req) begin
        st_next           = '0;
        st_next.used_edge = {2'b00, cfg.max_band};
      end
      if (start_req && cfg.total_bands == 7'd0) begin
        // empty element: one closing result, no bits consumed
        st_next.finished = 1'b1;
        push.cnt         = 2'd1;
        push.r0.last     = 1'b1;
      end else if (!st_next.finished) begin
        shift_v       = {st_next.shift[3:0], stream_bit};
        taken_v       = st_next.taken + 3'd1;
        st_next.shift = shift_v;
        st_next.taken = taken_v;
        len_val       = cfg.is_long ? shift_v : {2'b00, shift_v[2:0]};
        if (!st_next.reading) begin
          if (taken_v >= aacsd_pkg::CODEBOOK_BITS) begin
            st_next.cb      = shift_v[3:0];
            st_next.reading = 1'b1;
            st_next.shift   = '0;
            st_next.taken   = '0;
          end
        end else if (taken_v >= len_bits) begin
          st_next.shift = '0;
          st_next.taken = '0;
          if (len_val == esc && st_next.bp < total8) begin
            st_next.bp = aacsd_pkg::sat_add8(st_next.bp, {3'b000, esc});
          end else begin
            bp1 = aacsd_pkg::sat_add8(st_next.bp, {3'b000, len_val});
            bp2 = bp1;
            push.cnt            = 2'd1;
            push.r0.codebook    = st_next.cb;
            push.r0.section_end = bp1;
            st_next.sc = aacsd_pkg::sat_add8(st_next.sc, 8'd1);
            if (bp1 == st_next.used_edge) begin
              // jump to the group edge, clamped to a byte
              nb = $signed({2'b00, bp1}) + $signed({4'b0000, cfg.bands_per_window})
                   - $signed({4'b0000, cfg.max_band});
              if (nb < 0) begin
                bp2 = 8'd0;
              end else if (nb > 10'sd255) begin
                bp2 = 8'hFF;
              end else begin
                bp2 = nb[7:0];
              end
              if (cfg.is_long) begin
                done = 1'b1;
              end else begin
                if (cfg.bands_per_window != cfg.max_band) begin
                  push.cnt            = 2'd2;
                  push.r1.section_end = bp2;
                  push.r1.is_filler   = 1'b1;
                  st_next.sc = aacsd_pkg::sat_add8(st_next.sc, 8'd1);
                end
                st_next.used_edge = aacsd_pkg::sat_add8(st_next.used_edge,
                                                        {2'b00, cfg.bands_per_window});
              end
            end
            st_next.bp      = bp2;
            st_next.reading = 1'b0;
            if (done || bp2 >= total8 || st_next.sc >= total8) begin
              st_next.finished = 1'b1;
              err = (bp2 != total8) || (st_next.sc > total8);
              if (push.cnt == 2'd2) begin
                push.r1.last  = 1'b1;
                push.r1.error = err;
              end else begin
                push.r0.last  = 1'b1;
                push.r0.error = err;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{shift: 5'd0, taken: 3'd0, reading: 1'b0, cb: 4'd0, bp: 8'd0, sc: 8'd0,
              used_edge: 8'd0, finished: 1'b1};
    end else begin
      st <= st_next;
    end
  end

endmodule

// File: hw/rtl/aacsd_fifo.sv
// result queue: takes up to two results a cycle, hands out one
module aacsd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  aacsd_pkg::push_t   push,
  input  logic               pop,
  output aacsd_pkg::result_t head,
  output logic               head_valid,
  output logic               room_two
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  aacsd_pkg::result_t mem [DEPTH];
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [CW-1:0] count;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign room_two   = (count <= CW'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.cnt);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + CW'(push.cnt) - CW'(pop);
    end
  end

endmodule

// File: hw/rtl/aac_section_data_parser_top.sv
// top level of the aac section data parser: config registers, parse core, result queue
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_ready, stream_bit, start_req        | in
//   out     | out_valid, out_ready, codebook, section_end,     | out
//           | is_filler, last, error                           |
//   cfg     | psel, penable, pwrite, paddr, pwdata, prdata,    | in/out
//           | pready                                           |
//
// one bit item is taken per cycle while in_ready is high; its results enter the queue
// at that edge and show on out_valid the next cycle. an item gives zero, one or two
// results. in_ready stays high while the queue has room for two results (FIFO_DEPTH,
// a power of two, at least 2); an unstalled output drains it one result a cycle.
// rst clears the parse state to idle and the registers to their defaults.
module aac_section_data_parser_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        stream_bit,
  input  logic        start_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  codebook,
  output logic [7:0]  section_end,
  output logic        is_filler,
  output logic        last,
  output logic        error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  aacsd_pkg::cfg_t    cfg;
  aacsd_pkg::push_t   push;
  aacsd_pkg::result_t head;
  logic               step;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign step   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.is_long          <= 1'b1;
      cfg.bands_per_window <= 6'd49;
      cfg.max_band         <= 6'd49;
      cfg.total_bands      <= 7'd49;
    end else if (wr_en) begin
      case (paddr[3:2])
        aacsd_pkg::REG_IS_LONG:          cfg.is_long          <= pwdata[0];
        aacsd_pkg::REG_BANDS_PER_WINDOW: cfg.bands_per_window <= pwdata[5:0];
        aacsd_pkg::REG_MAX_BAND:         cfg.max_band         <= pwdata[5:0];
        aacsd_pkg::REG_TOTAL_BANDS:      cfg.total_bands      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      aacsd_pkg::REG_IS_LONG:          prdata = {31'd0, cfg.is_long};
      aacsd_pkg::REG_BANDS_PER_WINDOW: prdata = {26'd0, cfg.bands_per_window};
      aacsd_pkg::REG_MAX_BAND:         prdata = {26'd0, cfg.max_band};
      aacsd_pkg::REG_TOTAL_BANDS:      prdata = {25'd0, cfg.total_bands};
      default:                         prdata = '0;
    endcase
  end

  aacsd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .stream_bit (stream_bit),
    .start_req  (start_req),
    .cfg        (cfg),
    .push       (push)
  );

  aacsd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (out_valid && out_ready),
    .head       (head),
    .head_valid (out_valid),
    .room_two   (in_ready)
  );

  assign codebook    = head.codebook;
  assign section_end = head.section_end;
  assign is_filler   = head.is_filler;
  assign last        = head.last;
  assign error       = head.error;

endmodule

// File: hw/rtl/aacsd_checker.sv
// port-level checks of the aac section data parser and their bind
module aacsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] codebook,
  input logic [7:0] section_end,
  input logic       is_filler,
  input logic       last,
  input logic       error
);

  // nothing is queued right after reset
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(section_end) && $stable(codebook) && $stable(last))
    else $error("stalled result changed");

  // error is only ever reported on the closing section
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last)
    else $error("error without last");

  a_filler_cb: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_filler |-> codebook == 4'd0)
    else $error("filler section with nonzero codebook");

endmodule

bind aac_section_data_parser_top aacsd_checker u_aacsd_checker (.*);
